@@ rtl/core/ils_pkg.sv @@
// ----------------------------------------------------------------------------
// ils_pkg
// Shared types and constants for the indexed list store: request codes,
// field widths, controller states and the result bundle.
// ----------------------------------------------------------------------------
package ils_pkg;

    localparam int CAPACITY_DEF = 64;

    localparam int FUNC_W = 3;
    localparam int POS_W  = 16;
    localparam int DATA_W = 32;
    localparam int LEN_W  = 7;

    localparam logic [FUNC_W-1:0] FN_READ      = 3'd0;
    localparam logic [FUNC_W-1:0] FN_INS_FRONT = 3'd1;
    localparam logic [FUNC_W-1:0] FN_INS_BACK  = 3'd2;
    localparam logic [FUNC_W-1:0] FN_INS_AT    = 3'd3;
    localparam logic [FUNC_W-1:0] FN_DELETE    = 3'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_SHIFT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] read_value;
        logic                     done_ok;
        logic [LEN_W-1:0]         list_length;
    } res_t;

endpackage

@@ rtl/core/ils_if.sv @@
// ----------------------------------------------------------------------------
// ils_if
// Valid/ready channels of the indexed list store: request and result.
// ----------------------------------------------------------------------------
interface ils_req_if;
    logic                             valid;
    logic                             ready;
    logic [ils_pkg::FUNC_W-1:0]       func;
    logic [ils_pkg::POS_W-1:0]        position;
    logic signed [ils_pkg::DATA_W-1:0] item_value;

    modport source (output valid, output func, output position, output item_value,
                    input ready);
    modport sink   (input valid, input func, input position, input item_value,
                    output ready);
endinterface

interface ils_rsp_if;
    logic                              valid;
    logic                              ready;
    logic signed [ils_pkg::DATA_W-1:0] read_value;
    logic                              done_ok;
    logic [ils_pkg::LEN_W-1:0]         list_length;

    modport source (output valid, output read_value, output done_ok, output list_length,
                    input ready);
    modport sink   (input valid, input read_value, input done_ok, input list_length,
                    output ready);
endinterface

@@ rtl/core/indexed_list_store.sv @@
// ----------------------------------------------------------------------------
// indexed_list_store
// Ordered list of signed 32-bit values in a bounded element memory, with
// read, insert front/back/at and delete requests; one result per request.
// ----------------------------------------------------------------------------
// Elements sit in one synchronous memory in list order, so an insert or a
// delete moves every later element by one entry, one entry per cycle through
// the memory's single read port and single write port. A new request is
// accepted while the previous result still waits in the output register.
// ----------------------------------------------------------------------------
module indexed_list_store #(
    parameter int CAPACITY = ils_pkg::CAPACITY_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    ils_req_if.sink   req,
    ils_rsp_if.source rsp
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    logic                              ram_wr_en;
    logic [AW-1:0]                     ram_wr_addr;
    logic signed [ils_pkg::DATA_W-1:0] ram_wr_data;
    logic                              ram_rd_en;
    logic [AW-1:0]                     ram_rd_addr;
    logic signed [ils_pkg::DATA_W-1:0] ram_rd_data;

    logic          res_valid;
    logic          res_ready;
    ils_pkg::res_t res;

    logic          rsp_valid_reg;
    ils_pkg::res_t rsp_data_reg;

    ils_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res)
    );

    ils_ram #(
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // output item register
    assign res_ready = !rsp_valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            rsp_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            rsp_data_reg <= res;
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.read_value  = rsp_data_reg.read_value;
    assign rsp.done_ok     = rsp_data_reg.done_ok;
    assign rsp.list_length = rsp_data_reg.list_length;

endmodule

@@ rtl/core/ils_ram.sv @@
// ----------------------------------------------------------------------------
// ils_ram
// Element memory: one write port and one read port, registered read data.
// ----------------------------------------------------------------------------
module ils_ram #(
    parameter int  DEPTH = ils_pkg::CAPACITY_DEF,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                              clk,
    input  logic                              wr_en,
    input  logic [AW-1:0]                     wr_addr,
    input  logic signed [ils_pkg::DATA_W-1:0] wr_data,
    input  logic                              rd_en,
    input  logic [AW-1:0]                     rd_addr,
    output logic signed [ils_pkg::DATA_W-1:0] rd_data
);

    logic signed [ils_pkg::DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ rtl/core/ils_ctrl.sv @@
// ----------------------------------------------------------------------------
// ils_ctrl
// Request sequencer: decodes a request, runs reads and the one-entry-per-cycle
// shift of inserts and deletes through the element memory, keeps the length.
// ----------------------------------------------------------------------------
module ils_ctrl #(
    parameter int  CAPACITY = ils_pkg::CAPACITY_DEF,
    localparam int AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
    localparam int CW       = $clog2(CAPACITY + 1)
) (
    input  logic                              clk,
    input  logic                              rst_n,
    ils_req_if.sink                           req,
    output logic                              ram_wr_en,
    output logic [AW-1:0]                     ram_wr_addr,
    output logic signed [ils_pkg::DATA_W-1:0] ram_wr_data,
    output logic                              ram_rd_en,
    output logic [AW-1:0]                     ram_rd_addr,
    input  logic signed [ils_pkg::DATA_W-1:0] ram_rd_data,
    output logic                              res_valid,
    input  logic                              res_ready,
    output ils_pkg::res_t                     res
);

    localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

    ils_pkg::state_t state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [AW-1:0]   dst_reg, dst_next;
    logic [AW-1:0]   end_reg, end_next;
    logic [AW-1:0]   wdst_reg, wdst_next;
    logic            ins_reg, ins_next;
    logic            wpend_reg, wpend_next;
    logic signed [ils_pkg::DATA_W-1:0] val_reg, val_next;
    logic signed [ils_pkg::DATA_W-1:0] res_value_reg, res_value_next;
    logic            res_ok_reg, res_ok_next;

    logic room;
    logic pos_in_len;
    logic pos_le_len;

    assign room       = (count_reg != CAP_CNT);
    assign pos_in_len = (req.position <  ils_pkg::POS_W'(count_reg));
    assign pos_le_len = (req.position <= ils_pkg::POS_W'(count_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ils_pkg::ST_IDLE;
            count_reg <= '0;
            wpend_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            wpend_reg <= wpend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dst_reg       <= dst_next;
        end_reg       <= end_next;
        wdst_reg      <= wdst_next;
        ins_reg       <= ins_next;
        val_reg       <= val_next;
        res_value_reg <= res_value_next;
        res_ok_reg    <= res_ok_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        dst_next       = dst_reg;
        end_next       = end_reg;
        wdst_next      = wdst_reg;
        ins_next       = ins_reg;
        wpend_next     = wpend_reg;
        val_next       = val_reg;
        res_value_next = res_value_reg;
        res_ok_next    = res_ok_reg;

        req.ready   = 1'b0;
        res_valid   = 1'b0;
        ram_wr_en   = 1'b0;
        ram_wr_addr = wdst_reg;
        ram_wr_data = ram_rd_data;
        ram_rd_en   = 1'b0;
        ram_rd_addr = ins_reg ? (dst_reg - AW'(1)) : (dst_reg + AW'(1));

        unique case (state_reg)
            ils_pkg::ST_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    val_next       = req.item_value;
                    wpend_next     = 1'b0;
                    res_value_next = '0;
                    res_ok_next    = 1'b0;
                    state_next     = ils_pkg::ST_DONE;
                    unique case (req.func)
                        ils_pkg::FN_READ:
                        begin
                            if (pos_in_len)
                            begin
                                ram_rd_en   = 1'b1;
                                ram_rd_addr = AW'(req.position);
                                state_next  = ils_pkg::ST_READ;
                            end
                            else
                            begin
                                res_value_next = '1;
                            end
                        end
                        ils_pkg::FN_INS_FRONT:
                        begin
                            if (room)
                            begin
                                ins_next   = 1'b1;
                                dst_next   = AW'(count_reg);
                                end_next   = '0;
                                state_next = ils_pkg::ST_SHIFT;
                            end
                        end
                        ils_pkg::FN_INS_BACK:
                        begin
                            if (room)
                            begin
                                ins_next   = 1'b1;
                                dst_next   = AW'(count_reg);
                                end_next   = AW'(count_reg);
                                state_next = ils_pkg::ST_SHIFT;
                            end
                        end
                        ils_pkg::FN_INS_AT:
                        begin
                            if (room && pos_le_len)
                            begin
                                ins_next   = 1'b1;
                                dst_next   = AW'(count_reg);
                                end_next   = AW'(req.position);
                                state_next = ils_pkg::ST_SHIFT;
                            end
                        end
                        ils_pkg::FN_DELETE:
                        begin
                            if (pos_in_len)
                            begin
                                ins_next   = 1'b0;
                                dst_next   = AW'(req.position);
                                end_next   = AW'(count_reg - CW'(1));
                                state_next = ils_pkg::ST_SHIFT;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ils_pkg::ST_READ:
            begin
                res_value_next = ram_rd_data;
                res_ok_next    = 1'b1;
                state_next     = ils_pkg::ST_DONE;
            end

            ils_pkg::ST_SHIFT:
            begin
                // write of the entry read last cycle
                if (wpend_reg)
                begin
                    ram_wr_en = 1'b1;
                end
                if (dst_reg != end_reg)
                begin
                    ram_rd_en  = 1'b1;
                    wpend_next = 1'b1;
                    wdst_next  = dst_reg;
                    dst_next   = ram_rd_addr;
                end
                else
                begin
                    wpend_next = 1'b0;
                    if (!wpend_reg)
                    begin
                        if (ins_reg)
                        begin
                            ram_wr_en   = 1'b1;
                            ram_wr_addr = end_reg;
                            ram_wr_data = val_reg;
                            count_next  = count_reg + CW'(1);
                        end
                        else
                        begin
                            count_next = count_reg - CW'(1);
                        end
                        res_value_next = '0;
                        res_ok_next    = 1'b1;
                        state_next     = ils_pkg::ST_DONE;
                    end
                end
            end

            ils_pkg::ST_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = ils_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = ils_pkg::ST_IDLE;
            end
        endcase
    end

    assign res.read_value  = res_value_reg;
    assign res.done_ok     = res_ok_reg;
    assign res.list_length = ils_pkg::LEN_W'(count_reg);

endmodule
